@@ hdl/blca_pkg.sv @@
package blca_pkg;

    localparam int NODE_W  = 15;
    localparam int LEN_W   = 16;
    localparam int TOTAL_W = 40;

    localparam logic [LEN_W-1:0]   LEN_MAX   = 16'hFFFE;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_B_INIT,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_DEPTH,
        S_Q_SWAP,
        S_Q_LIFT,
        S_Q_LIFT_A,
        S_Q_LIFT_D,
        S_Q_EQ,
        S_Q_CL_RD,
        S_Q_CL_CMP,
        S_Q_PAR,
        S_Q_PAR_D,
        S_Q_ANC_D,
        S_Q_LEN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic build_init;
        logic build_wr;
        logic anc_rd_x;
        logic anc_rd_up;
        logic dep_rd_cur;
        logic q_swap;
        logic lvl_dec;
        logic lvl_top;
        logic lift_take;
        logic lift_depth;
        logic eq_hit;
        logic cl_step;
        logic par_take;
        logic anc_depth;
        logic calc_len;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic op_load;
        logic op_build;
        logic op_query;
        logic build_empty;
        logic build_last;
        logic lift_cond;
        logic lvl_zero;
        logic a_eq_b;
    } status_t;

endpackage

@@ hdl/binary_lifting_lca_path_length_core.sv @@
// Lowest common ancestor and path length by binary lifting. A request is taken when start is
// high and busy is low; its single result appears for one cycle with done high and cannot be
// held off, and a new request may be given in that same cycle. Each read of the ancestor table
// is registered, and so is each read of the depth store. A load writes both stores. A build
// fills levels 1 to JUMP_LEVELS-1 of the ancestor table for nodes 1 to n with
// n = min(node_count, NODE_SLOTS-1), each entry from two chained table reads. A query reads
// both depths, lifts the deeper node (a table read then a depth read per lifted level), then
// climbs both nodes jointly level by level. Both stores are undefined after reset and need no
// clearing. The user writes node_count only while busy is low; the block does not enforce it.
module binary_lifting_lca_path_length_core #(
    parameter int NODE_SLOTS  = 32768,
    parameter int JUMP_LEVELS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          node_count_we,
    input  logic [blca_pkg::NODE_W-1:0]   node_count,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [blca_pkg::NODE_W-1:0]   node,
    input  logic [blca_pkg::NODE_W-1:0]   parent_node,
    input  logic [blca_pkg::NODE_W-1:0]   node_depth,
    output logic                          done,
    output logic [blca_pkg::NODE_W-1:0]   ancestor,
    output logic [blca_pkg::LEN_W-1:0]    path_length,
    output logic [blca_pkg::TOTAL_W-1:0]  total_length,
    output logic                          total_saturated
);

    blca_pkg::cmd_t    cmd;
    blca_pkg::status_t sts;

    blca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    blca_dp #(
        .NODE_SLOTS  (NODE_SLOTS),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .node_count_we   (node_count_we),
        .node_count      (node_count),
        .opcode          (opcode),
        .node            (node),
        .parent_node     (parent_node),
        .node_depth      (node_depth),
        .done            (done),
        .ancestor        (ancestor),
        .path_length     (path_length),
        .total_length    (total_length),
        .total_saturated (total_saturated)
    );

endmodule

@@ hdl/blca_ctrl.sv @@
module blca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  blca_pkg::status_t  sts,
    output blca_pkg::cmd_t     cmd,
    output logic               busy
);

    blca_pkg::state_t state_reg;
    blca_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blca_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            blca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = blca_pkg::S_DISPATCH;
                end
            end
            blca_pkg::S_DISPATCH:
            begin
                if (sts.op_load)
                    state_next = blca_pkg::S_LOAD;
                else if (sts.op_build)
                    state_next = blca_pkg::S_B_INIT;
                else if (sts.op_query)
                    state_next = blca_pkg::S_Q_DEPTH;
                else
                    state_next = blca_pkg::S_DONE;
            end
            blca_pkg::S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = blca_pkg::S_DONE;
            end
            blca_pkg::S_B_INIT:
            begin
                cmd.build_init = 1'b1;
                state_next = sts.build_empty ? blca_pkg::S_DONE : blca_pkg::S_B_RD1;
            end
            blca_pkg::S_B_RD1:
            begin
                cmd.anc_rd_x = 1'b1;
                state_next   = blca_pkg::S_B_RD2;
            end
            blca_pkg::S_B_RD2:
            begin
                cmd.anc_rd_up = 1'b1;
                state_next    = blca_pkg::S_B_WR;
            end
            blca_pkg::S_B_WR:
            begin
                cmd.build_wr = 1'b1;
                state_next = sts.build_last ? blca_pkg::S_DONE : blca_pkg::S_B_RD1;
            end
            blca_pkg::S_Q_DEPTH:
            begin
                cmd.dep_rd_cur = 1'b1;
                state_next     = blca_pkg::S_Q_SWAP;
            end
            blca_pkg::S_Q_SWAP:
            begin
                cmd.q_swap  = 1'b1;
                cmd.lvl_top = 1'b1;
                state_next  = blca_pkg::S_Q_LIFT;
            end
            blca_pkg::S_Q_LIFT:
            begin
                if (sts.lift_cond)
                    state_next = blca_pkg::S_Q_LIFT_A;
                else if (sts.lvl_zero)
                    state_next = blca_pkg::S_Q_EQ;
                else
                    cmd.lvl_dec = 1'b1;
            end
            blca_pkg::S_Q_LIFT_A:
            begin
                cmd.lift_take = 1'b1;
                state_next    = blca_pkg::S_Q_LIFT_D;
            end
            blca_pkg::S_Q_LIFT_D:
            begin
                cmd.lift_depth = 1'b1;
                if (sts.lvl_zero)
                begin
                    state_next = blca_pkg::S_Q_EQ;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = blca_pkg::S_Q_LIFT;
                end
            end
            blca_pkg::S_Q_EQ:
            begin
                if (sts.a_eq_b)
                begin
                    cmd.eq_hit = 1'b1;
                    state_next = blca_pkg::S_Q_LEN;
                end
                else
                begin
                    cmd.lvl_top = 1'b1;
                    state_next  = blca_pkg::S_Q_CL_RD;
                end
            end
            blca_pkg::S_Q_CL_RD:
            begin
                state_next = blca_pkg::S_Q_CL_CMP;
            end
            blca_pkg::S_Q_CL_CMP:
            begin
                cmd.cl_step = 1'b1;
                if (sts.lvl_zero)
                begin
                    state_next = blca_pkg::S_Q_PAR;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = blca_pkg::S_Q_CL_RD;
                end
            end
            blca_pkg::S_Q_PAR:
            begin
                state_next = blca_pkg::S_Q_PAR_D;
            end
            blca_pkg::S_Q_PAR_D:
            begin
                cmd.par_take = 1'b1;
                state_next   = blca_pkg::S_Q_ANC_D;
            end
            blca_pkg::S_Q_ANC_D:
            begin
                cmd.anc_depth = 1'b1;
                state_next    = blca_pkg::S_Q_LEN;
            end
            blca_pkg::S_Q_LEN:
            begin
                cmd.calc_len = 1'b1;
                state_next   = blca_pkg::S_DONE;
            end
            blca_pkg::S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = blca_pkg::S_IDLE;
            end
            default:
            begin
                state_next = blca_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != blca_pkg::S_IDLE);

endmodule

@@ hdl/blca_dp.sv @@
module blca_dp #(
    parameter int NODE_SLOTS  = 32768,
    parameter int JUMP_LEVELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  blca_pkg::cmd_t                   cmd,
    output blca_pkg::status_t                sts,
    input  logic                             node_count_we,
    input  logic [blca_pkg::NODE_W-1:0]      node_count,
    input  logic [1:0]                       opcode,
    input  logic [blca_pkg::NODE_W-1:0]      node,
    input  logic [blca_pkg::NODE_W-1:0]      parent_node,
    input  logic [blca_pkg::NODE_W-1:0]      node_depth,
    output logic                             done,
    output logic [blca_pkg::NODE_W-1:0]      ancestor,
    output logic [blca_pkg::LEN_W-1:0]       path_length,
    output logic [blca_pkg::TOTAL_W-1:0]     total_length,
    output logic                             total_saturated
);

    localparam int NW       = blca_pkg::NODE_W;
    localparam int IW       = $clog2(NODE_SLOTS);
    localparam int AW       = $clog2(NODE_SLOTS * JUMP_LEVELS);
    localparam int LW       = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int ANC_SIZE = NODE_SLOTS * JUMP_LEVELS;

    function automatic logic node_ok(input logic [NW-1:0] x);
        node_ok = (x != '0) && (32'(x) < NODE_SLOTS);
    endfunction

    function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] x,
                                               input logic [AW-1:0] l);
        anc_addr = AW'(x) * AW'(JUMP_LEVELS) + l;
    endfunction

    // memories
    logic [NW-1:0] anc_mem [ANC_SIZE];
    logic [NW-1:0] dep_mem [NODE_SLOTS];

    logic [NW-1:0] anc_rd0_reg, anc_rd1_reg;
    logic [NW-1:0] dep_rd0_reg, dep_rd1_reg;
    logic          anc_v0_reg, anc_v1_reg;
    logic          dep_v0_reg, dep_v1_reg;

    // control and payload registers
    logic [1:0]                    op_reg;
    logic [NW-1:0]                 nd_reg, par_reg, dep_reg;
    logic [NW-1:0]                 a_reg, b_reg, da_reg, db_reg;
    logic [NW-1:0]                 anc_reg, danc_reg;
    logic [blca_pkg::LEN_W-1:0]    dsum_reg, len_reg;
    logic [LW-1:0]                 lvl_reg;
    logic [NW-1:0]                 x_reg, xlast_reg;
    logic [NW-1:0]                 cur_reg;
    logic [NW-1:0]                 node_count_reg;
    logic [blca_pkg::TOTAL_W-1:0]  total_reg;
    logic                          sat_reg;
    logic                          done_reg;
    logic [NW-1:0]                 ancestor_reg;
    logic [blca_pkg::LEN_W-1:0]    path_length_reg;

    logic [NW-1:0] up0, up1, dep0, dep1;
    logic [NW-1:0] anc_node0, dep_node0;
    logic [AW-1:0] anc_ra0, anc_ra1, anc_wa;
    logic [NW-1:0] anc_wd;
    logic          anc_we, dep_we;
    logic [IW-1:0] dep_ra0, dep_ra1;
    logic [16:0]   lift_lim;
    logic [17:0]   diff;
    logic [blca_pkg::TOTAL_W:0] sum;

    assign up0  = anc_v0_reg ? anc_rd0_reg : '0;
    assign up1  = anc_v1_reg ? anc_rd1_reg : '0;
    assign dep0 = dep_v0_reg ? dep_rd0_reg : '0;
    assign dep1 = dep_v1_reg ? dep_rd1_reg : '0;

    assign anc_node0 = cmd.anc_rd_x ? x_reg : (cmd.anc_rd_up ? up0 : a_reg);
    assign dep_node0 = cmd.dep_rd_cur ? cur_reg : up0;

    assign anc_ra0 = anc_addr(anc_node0, AW'(lvl_reg));
    assign anc_ra1 = anc_addr(b_reg, AW'(lvl_reg));
    assign dep_ra0 = IW'(dep_node0);
    assign dep_ra1 = IW'(nd_reg);

    always_comb
    begin
        anc_we = 1'b0;
        anc_wa = anc_addr(nd_reg, '0);
        anc_wd = par_reg;
        if (cmd.load_wr)
        begin
            anc_we = node_ok(nd_reg);
        end
        else if (cmd.build_wr)
        begin
            anc_we = 1'b1;
            anc_wa = anc_addr(x_reg, AW'(lvl_reg) + AW'(1));
            anc_wd = up0;
        end
    end

    assign dep_we = cmd.load_wr && node_ok(nd_reg);

    always_ff @(posedge clk)
    begin
        if (anc_we)
            anc_mem[anc_wa] <= anc_wd;
        anc_rd0_reg <= anc_mem[anc_ra0];
        anc_rd1_reg <= anc_mem[anc_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
            dep_mem[IW'(nd_reg)] <= dep_reg;
        dep_rd0_reg <= dep_mem[dep_ra0];
        dep_rd1_reg <= dep_mem[dep_ra1];
    end

    assign lift_lim = {2'b00, db_reg} + (17'd1 << lvl_reg);
    assign diff     = {2'b00, dsum_reg} - {2'b00, danc_reg, 1'b0};
    assign sum      = {1'b0, total_reg} + (blca_pkg::TOTAL_W + 1)'(len_reg);

    always_ff @(posedge clk)
    begin
        anc_v0_reg <= node_ok(anc_node0);
        anc_v1_reg <= node_ok(b_reg);
        dep_v0_reg <= node_ok(dep_node0);
        dep_v1_reg <= node_ok(nd_reg);

        if (cmd.capture)
        begin
            op_reg  <= opcode;
            nd_reg  <= node;
            par_reg <= parent_node;
            dep_reg <= node_depth;
        end

        if (cmd.build_init)
        begin
            x_reg <= NW'(1);
            xlast_reg <= (32'(node_count_reg) > NODE_SLOTS - 1) ? NW'(NODE_SLOTS - 1)
                                                                  : node_count_reg;
        end
        else if (cmd.build_wr)
        begin
            x_reg <= (x_reg == xlast_reg) ? NW'(1) : x_reg + NW'(1);
        end

        if (cmd.build_init)
            lvl_reg <= '0;
        else if (cmd.build_wr && x_reg == xlast_reg)
            lvl_reg <= lvl_reg + LW'(1);
        else if (cmd.lvl_top)
            lvl_reg <= LW'(JUMP_LEVELS - 1);
        else if (cmd.lvl_dec)
            lvl_reg <= lvl_reg - LW'(1);

        if (cmd.q_swap)
        begin
            dsum_reg <= blca_pkg::LEN_W'(dep0) + blca_pkg::LEN_W'(dep1);
            if (dep0 < dep1)
            begin
                a_reg  <= nd_reg;
                b_reg  <= cur_reg;
                da_reg <= dep1;
                db_reg <= dep0;
            end
            else
            begin
                a_reg  <= cur_reg;
                b_reg  <= nd_reg;
                da_reg <= dep0;
                db_reg <= dep1;
            end
        end
        else if (cmd.lift_take)
        begin
            a_reg <= up0;
        end
        else if (cmd.cl_step && up0 != '0 && up0 != up1)
        begin
            a_reg <= up0;
            b_reg <= up1;
        end

        if (cmd.lift_depth)
            da_reg <= dep0;

        if (cmd.eq_hit)
        begin
            anc_reg  <= a_reg;
            danc_reg <= da_reg;
        end
        else if (cmd.par_take)
        begin
            anc_reg <= up0;
        end
        else if (cmd.anc_depth)
        begin
            danc_reg <= dep0;
        end

        if (cmd.calc_len)
        begin
            if (diff[17])
                len_reg <= '0;
            else if (diff > 18'(blca_pkg::LEN_MAX))
                len_reg <= blca_pkg::LEN_MAX;
            else
                len_reg <= diff[blca_pkg::LEN_W-1:0];
        end

        if (cmd.finish)
        begin
            ancestor_reg    <= sts.op_query ? anc_reg : '0;
            path_length_reg <= sts.op_query ? len_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NW'(1);
            cur_reg        <= NW'(1);
            total_reg      <= '0;
            sat_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (node_count_we)
                node_count_reg <= node_count;
            done_reg <= cmd.finish;
            if (cmd.finish && sts.op_query)
            begin
                cur_reg <= nd_reg;
                if (sum >= {1'b0, blca_pkg::TOTAL_MAX})
                begin
                    total_reg <= blca_pkg::TOTAL_MAX;
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    total_reg <= sum[blca_pkg::TOTAL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        sts.op_load     = (op_reg == blca_pkg::OP_LOAD);
        sts.op_build    = (op_reg == blca_pkg::OP_BUILD);
        sts.op_query    = (op_reg == blca_pkg::OP_QUERY);
        sts.build_empty = (JUMP_LEVELS < 2) || (node_count_reg == '0);
        sts.build_last  = (x_reg == xlast_reg) && (32'(lvl_reg) == JUMP_LEVELS - 2);
        sts.lift_cond   = ({2'b00, da_reg} >= lift_lim);
        sts.lvl_zero    = (lvl_reg == '0);
        sts.a_eq_b      = (a_reg == b_reg);
    end

    assign done            = done_reg;
    assign ancestor        = ancestor_reg;
    assign path_length     = path_length_reg;
    assign total_length    = total_reg;
    assign total_saturated = sat_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |=> sat_reg)
        else $error("saturation flag cleared");

    a_sat_total: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (total_reg == blca_pkg::TOTAL_MAX))
        else $error("saturated total below maximum");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(total_reg))
        else $error("running total changed outside result cycle");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(lvl_reg) < JUMP_LEVELS) || !(cmd.lvl_dec || cmd.cl_step || cmd.lift_take))
        else $error("jump level out of range");

endmodule
